// ===== rtl/hpx_pkg.sv =====
// ----------------------------------------------------------------------------
// hpx_pkg
// Shared types, constants and microcode encoding for the headphone crossfeed.
// ----------------------------------------------------------------------------
package hpx_pkg;

	localparam int SAMPLE_BITS  = 24;
	localparam int STATE_BITS   = SAMPLE_BITS + 4;
	localparam int COEF_BITS    = 24;
	localparam int COEF_FRAC    = 22;
	localparam int NUM_REGS     = 6;
	localparam int REG_IDX_BITS = $clog2(NUM_REGS);
	localparam int STEP_BITS    = 4;

	// register indexes, also the coefficient select of the microcode
	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_LP_IN    = 3'd0,
		REG_LP_FB    = 3'd1,
		REG_BST_IN   = 3'd2,
		REG_BST_PREV = 3'd3,
		REG_BST_FB   = 3'd4,
		REG_GAIN     = 3'd5
	} reg_idx_e;

	localparam logic signed [COEF_BITS-1:0] CFG_RESET [NUM_REGS] = '{
		24'sd201452,
		24'sd3796180,
		24'sd4057528,
		-24'sd3631428,
		24'sd3631428,
		24'sd3689730
	};

	localparam logic [STEP_BITS-1:0] STEP_IDLE = 4'd0;
	localparam logic [STEP_BITS-1:0] STEP_LAST = 4'd15;

	// sequencing of a step
	typedef enum logic [1:0] {
		SEQ_NEXT,     // go to following step
		SEQ_WAIT_IN,  // hold until an input beat arrives
		SEQ_WAIT_OUT  // hold until the output register is free, then back to idle
	} seq_e;

	// multiplier operand select
	typedef enum logic [3:0] {
		OP_XL,
		OP_XR,
		OP_PL,
		OP_PR,
		OP_LPL,
		OP_LPR,
		OP_BSL,
		OP_BSR,
		OP_SUML,
		OP_SUMR
	} opnd_e;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_e;

	typedef enum logic [2:0] {
		WB_NONE,
		WB_LPL,
		WB_LPR,
		WB_BSL,
		WB_BSR,
		WB_RESL,
		WB_PREV
	} wb_e;

	typedef struct packed {
		seq_e     seq;
		reg_idx_e coef;
		opnd_e    opnd;
		acc_e     acc;
		wb_e      wb;
	} ctrl_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
		logic                          frame_end;
	} in_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_result;
		logic signed [SAMPLE_BITS-1:0] right_result;
		logic                          frame_end_out;
	} out_beat_t;

endpackage

// ===== rtl/stereo_headphone_crossfeed.sv =====
// ----------------------------------------------------------------------------
// stereo_headphone_crossfeed
// Microcoded crossfeed: lowpass + high-boost per channel, cross-summed, gained.
// ----------------------------------------------------------------------------
//  channel  | signals                          | beat
//  ---------+----------------------------------+---------------------------------
//  in       | in_valid, in_stall, in_data      | one stereo pair, Q1.23
//  out      | out_valid, out_stall, out_data   | one crossfed pair, Q1.23
//  cfg      | cfg_wr_en, cfg_index, cfg_data   | one Q2.22 register write
//
//  Each pair runs one idle step that takes the beat, then 15 microcode
//  steps through the single shared multiplier and accumulator.
//  Reset restores the coefficient defaults and clears all filter history.
//  A finished pair sits in the output register; the next pair is taken and
//  worked on meanwhile, and the sequencer holds on its last step only while
//  the output register is still full and stalled.
// ----------------------------------------------------------------------------
module stereo_headphone_crossfeed (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  hpx_pkg::in_beat_t                       in_data,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output hpx_pkg::out_beat_t                      out_data,
	input  logic                                    cfg_wr_en,
	input  logic [hpx_pkg::REG_IDX_BITS-1:0]        cfg_index,
	input  logic [hpx_pkg::COEF_BITS-1:0]           cfg_data
);

	logic [hpx_pkg::STEP_BITS-1:0]         step_q;
	logic signed [hpx_pkg::COEF_BITS-1:0]  cfg_q [hpx_pkg::NUM_REGS];
	logic                                  frame_q;
	logic                                  out_valid_q;
	hpx_pkg::out_beat_t                    out_data_q;

	hpx_pkg::ctrl_t                        ctrl;
	logic                                  in_take;
	logic                                  out_free;
	logic                                  finish;
	logic signed [hpx_pkg::COEF_BITS-1:0]  coef;
	logic signed [hpx_pkg::SAMPLE_BITS-1:0] res_l, res_r;

	// --- microcode ----------------------------------------------------------
	hpx_ucode_rom u_rom (
		.step (step_q),
		.ctrl (ctrl)
	);

	// the idle step is the only one that takes an input beat
	assign in_stall = (ctrl.seq != hpx_pkg::SEQ_WAIT_IN);
	assign in_take  = in_valid && !in_stall;
	// output register empties this cycle or already is empty
	assign out_free = !out_valid_q || !out_stall;
	assign finish   = (ctrl.seq == hpx_pkg::SEQ_WAIT_OUT) && out_free;

	// step counter with conditional holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= hpx_pkg::STEP_IDLE;
		end else begin
			case (ctrl.seq)
				hpx_pkg::SEQ_WAIT_IN: begin
					if (in_take) begin
						step_q <= step_q + 1'b1;
					end
				end
				hpx_pkg::SEQ_WAIT_OUT: begin
					if (out_free) begin
						step_q <= hpx_pkg::STEP_IDLE;
					end
				end
				default: step_q <= step_q + 1'b1;
			endcase
		end
	end

	// --- configuration registers -------------------------------------------
	// out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hpx_pkg::NUM_REGS; i++) begin
				cfg_q[i] <= hpx_pkg::CFG_RESET[i];
			end
		end else if (cfg_wr_en && (cfg_index < hpx_pkg::REG_IDX_BITS'(hpx_pkg::NUM_REGS))) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	assign coef = cfg_q[ctrl.coef];

	// --- datapath -----------------------------------------------------------
	hpx_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.load_in (in_take),
		.in_data (in_data),
		.coef    (coef),
		.res_l   (res_l),
		.res_r   (res_r)
	);

	always_ff @(posedge clk) begin
		if (in_take) begin
			frame_q <= in_data.frame_end;
		end
	end

	// --- output register ----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q.left_result   <= res_l;
			out_data_q.right_result  <= res_r;
			out_data_q.frame_end_out <= frame_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef NO_ASSERTIONS
	// a result appears only when the program has reached its last step
	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(step_q) == hpx_pkg::STEP_LAST)
		else $error("output beat without finished program");

	// a taken input beat starts the program
	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> step_q == hpx_pkg::STEP_IDLE + 1'b1)
		else $error("input beat taken but program did not start");

	// a full, stalled output register keeps the sequencer on its last step
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == hpx_pkg::STEP_LAST && out_valid && out_stall |=>
		step_q == hpx_pkg::STEP_LAST && out_valid)
		else $error("result overwritten while output stalled");
`endif

endmodule

// ===== rtl/hpx_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// hpx_ucode_rom
// Microcode store: one control word per sequencer step.
// ----------------------------------------------------------------------------
module hpx_ucode_rom (
	input  logic [hpx_pkg::STEP_BITS-1:0] step,
	output hpx_pkg::ctrl_t                ctrl
);

	// The product is registered before the accumulator takes it; accumulator op and write-back
	// see the values registered at the previous edge.
	always_comb begin
		ctrl = '{seq: hpx_pkg::SEQ_NEXT, coef: hpx_pkg::REG_LP_IN, opnd: hpx_pkg::OP_XL,
			acc: hpx_pkg::ACC_HOLD, wb: hpx_pkg::WB_NONE};
		case (step)
			4'd0: begin
				ctrl.seq = hpx_pkg::SEQ_WAIT_IN;
			end
			4'd1: begin
				ctrl.coef = hpx_pkg::REG_LP_IN;    ctrl.opnd = hpx_pkg::OP_XL;
			end
			4'd2: begin
				ctrl.coef = hpx_pkg::REG_LP_FB;    ctrl.opnd = hpx_pkg::OP_LPL;
				ctrl.acc  = hpx_pkg::ACC_LOAD;
			end
			4'd3: begin
				ctrl.coef = hpx_pkg::REG_BST_IN;   ctrl.opnd = hpx_pkg::OP_XL;
				ctrl.acc  = hpx_pkg::ACC_ADD;
			end
			4'd4: begin
				ctrl.coef = hpx_pkg::REG_BST_PREV; ctrl.opnd = hpx_pkg::OP_PL;
				ctrl.acc  = hpx_pkg::ACC_LOAD;     ctrl.wb   = hpx_pkg::WB_LPL;
			end
			4'd5: begin
				ctrl.coef = hpx_pkg::REG_BST_FB;   ctrl.opnd = hpx_pkg::OP_BSL;
				ctrl.acc  = hpx_pkg::ACC_ADD;
			end
			4'd6: begin
				ctrl.coef = hpx_pkg::REG_LP_IN;    ctrl.opnd = hpx_pkg::OP_XR;
				ctrl.acc  = hpx_pkg::ACC_ADD;
			end
			4'd7: begin
				ctrl.coef = hpx_pkg::REG_LP_FB;    ctrl.opnd = hpx_pkg::OP_LPR;
				ctrl.acc  = hpx_pkg::ACC_LOAD;     ctrl.wb   = hpx_pkg::WB_BSL;
			end
			4'd8: begin
				ctrl.coef = hpx_pkg::REG_BST_IN;   ctrl.opnd = hpx_pkg::OP_XR;
				ctrl.acc  = hpx_pkg::ACC_ADD;
			end
			4'd9: begin
				ctrl.coef = hpx_pkg::REG_BST_PREV; ctrl.opnd = hpx_pkg::OP_PR;
				ctrl.acc  = hpx_pkg::ACC_LOAD;     ctrl.wb   = hpx_pkg::WB_LPR;
			end
			4'd10: begin
				ctrl.coef = hpx_pkg::REG_BST_FB;   ctrl.opnd = hpx_pkg::OP_BSR;
				ctrl.acc  = hpx_pkg::ACC_ADD;
			end
			4'd11: begin
				ctrl.coef = hpx_pkg::REG_GAIN;     ctrl.opnd = hpx_pkg::OP_SUML;
				ctrl.acc  = hpx_pkg::ACC_ADD;
			end
			4'd12: begin
				ctrl.acc  = hpx_pkg::ACC_LOAD;     ctrl.wb   = hpx_pkg::WB_BSR;
			end
			4'd13: begin
				ctrl.coef = hpx_pkg::REG_GAIN;     ctrl.opnd = hpx_pkg::OP_SUMR;
				ctrl.wb   = hpx_pkg::WB_RESL;
			end
			4'd14: begin
				ctrl.acc  = hpx_pkg::ACC_LOAD;
			end
			4'd15: begin
				ctrl.seq  = hpx_pkg::SEQ_WAIT_OUT; ctrl.wb   = hpx_pkg::WB_PREV;
			end
			default: begin
				ctrl.seq = hpx_pkg::SEQ_WAIT_IN;
			end
		endcase
	end

endmodule

// ===== rtl/hpx_datapath.sv =====
// ----------------------------------------------------------------------------
// hpx_datapath
// Shared multiply-accumulate, rounding/saturation and filter state.
// ----------------------------------------------------------------------------
module hpx_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  hpx_pkg::ctrl_t                        ctrl,
	input  logic                                  load_in,
	input  hpx_pkg::in_beat_t                     in_data,
	input  logic signed [hpx_pkg::COEF_BITS-1:0]  coef,
	output logic signed [hpx_pkg::SAMPLE_BITS-1:0] res_l,
	output logic signed [hpx_pkg::SAMPLE_BITS-1:0] res_r
);

	localparam int SB   = hpx_pkg::SAMPLE_BITS;
	localparam int STB  = hpx_pkg::STATE_BITS;
	localparam int FRAC = hpx_pkg::COEF_FRAC;
	localparam int OPW  = SB + 5;
	localparam int PW   = hpx_pkg::COEF_BITS + OPW;
	localparam int ACCW = PW + 2;
	localparam int RW   = ACCW + 1;
	localparam int SHS  = RW - FRAC;        // state path after shift
	localparam int SHR  = RW - FRAC - 2;    // result path after shift

	localparam logic signed [RW-1:0] RND_ST = {{(RW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic signed [RW-1:0] RND_RS = {{(RW-FRAC-2){1'b0}}, 1'b1, {(FRAC+1){1'b0}}};
	localparam logic signed [SHS-1:0] ST_MAX = {{(SHS-STB+1){1'b0}}, {(STB-1){1'b1}}};
	localparam logic signed [SHS-1:0] ST_MIN = {{(SHS-STB+1){1'b1}}, {(STB-1){1'b0}}};
	localparam logic signed [SHR-1:0] RS_MAX = {{(SHR-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [SHR-1:0] RS_MIN = {{(SHR-SB+1){1'b1}}, {(SB-1){1'b0}}};

	logic signed [SB-1:0]   x_l_q, x_r_q;
	logic signed [SB-1:0]   prev_q [2];
	logic signed [STB-1:0]  lp_q [2];
	logic signed [STB-1:0]  bs_q [2];
	logic signed [SB-1:0]   res_l_q;
	logic signed [PW-1:0]   product_s1;
	logic signed [ACCW-1:0] acc_q;

	logic signed [OPW-1:0]  opnd;
	logic signed [PW-1:0]   coef_w, opnd_w;
	logic signed [ACCW-1:0] prod_ext;
	logic signed [RW-1:0]   rnd_st, rnd_rs;
	logic signed [SHS-1:0]  sh_st;
	logic signed [SHR-1:0]  sh_rs;
	logic signed [STB-1:0]  st_new;
	logic signed [SB-1:0]   rs_new;

	always_comb begin
		case (ctrl.opnd)
			hpx_pkg::OP_XL:   opnd = {{3{x_l_q[SB-1]}}, x_l_q, 2'b00};
			hpx_pkg::OP_XR:   opnd = {{3{x_r_q[SB-1]}}, x_r_q, 2'b00};
			hpx_pkg::OP_PL:   opnd = {{3{prev_q[0][SB-1]}}, prev_q[0], 2'b00};
			hpx_pkg::OP_PR:   opnd = {{3{prev_q[1][SB-1]}}, prev_q[1], 2'b00};
			hpx_pkg::OP_LPL:  opnd = {lp_q[0][STB-1], lp_q[0]};
			hpx_pkg::OP_LPR:  opnd = {lp_q[1][STB-1], lp_q[1]};
			hpx_pkg::OP_BSL:  opnd = {bs_q[0][STB-1], bs_q[0]};
			hpx_pkg::OP_BSR:  opnd = {bs_q[1][STB-1], bs_q[1]};
			hpx_pkg::OP_SUML: opnd = {bs_q[0][STB-1], bs_q[0]} + {lp_q[1][STB-1], lp_q[1]};
			hpx_pkg::OP_SUMR: opnd = {bs_q[1][STB-1], bs_q[1]} + {lp_q[0][STB-1], lp_q[0]};
			default:          opnd = '0;
		endcase
	end

	assign coef_w   = {{(PW-hpx_pkg::COEF_BITS){coef[hpx_pkg::COEF_BITS-1]}}, coef};
	assign opnd_w   = {{(PW-OPW){opnd[OPW-1]}}, opnd};
	assign prod_ext = {{2{product_s1[PW-1]}}, product_s1};

	// round half up then clamp; state keeps Q3.25, result goes to Q1.23
	assign rnd_st = {acc_q[ACCW-1], acc_q} + RND_ST;
	assign rnd_rs = {acc_q[ACCW-1], acc_q} + RND_RS;
	assign sh_st  = rnd_st[RW-1:FRAC];
	assign sh_rs  = rnd_rs[RW-1:FRAC+2];

	always_comb begin
		if (sh_st > ST_MAX) begin
			st_new = ST_MAX[STB-1:0];
		end else if (sh_st < ST_MIN) begin
			st_new = ST_MIN[STB-1:0];
		end else begin
			st_new = sh_st[STB-1:0];
		end
		if (sh_rs > RS_MAX) begin
			rs_new = RS_MAX[SB-1:0];
		end else if (sh_rs < RS_MIN) begin
			rs_new = RS_MIN[SB-1:0];
		end else begin
			rs_new = sh_rs[SB-1:0];
		end
	end

	// arithmetic pipe, no reset needed
	always_ff @(posedge clk) begin
		product_s1 <= coef_w * opnd_w;
		case (ctrl.acc)
			hpx_pkg::ACC_LOAD: acc_q <= prod_ext;
			hpx_pkg::ACC_ADD:  acc_q <= acc_q + prod_ext;
			default:           acc_q <= acc_q;
		endcase
		if (load_in) begin
			x_l_q <= in_data.left_sample;
			x_r_q <= in_data.right_sample;
		end
		if (ctrl.wb == hpx_pkg::WB_RESL) begin
			res_l_q <= rs_new;
		end
	end

	// filter history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q[0]   <= '0;
			lp_q[1]   <= '0;
			bs_q[0]   <= '0;
			bs_q[1]   <= '0;
			prev_q[0] <= '0;
			prev_q[1] <= '0;
		end else begin
			case (ctrl.wb)
				hpx_pkg::WB_LPL: lp_q[0] <= st_new;
				hpx_pkg::WB_LPR: lp_q[1] <= st_new;
				hpx_pkg::WB_BSL: bs_q[0] <= st_new;
				hpx_pkg::WB_BSR: bs_q[1] <= st_new;
				hpx_pkg::WB_PREV: begin
					prev_q[0] <= x_l_q;
					prev_q[1] <= x_r_q;
				end
				default: ;
			endcase
		end
	end

	assign res_l = res_l_q;
	assign res_r = rs_new;

endmodule
